### sv/eph_pkg.sv
// ----------------------------------------------------------------------------
// Eulerian path package
// Shared widths, constants, result codes and memory control types.
// ----------------------------------------------------------------------------
package eph_pkg;

  localparam int VTX_W  = 7;
  localparam int EIDX_W = 6;
  localparam int DEG_W  = 6;

  localparam logic [EIDX_W-1:0] EMPTY_MARK   = 6'd63;
  localparam logic [VTX_W-1:0]  START_VERTEX = 7'd1;

  // Result status codes
  localparam logic [1:0] ST_PATH     = 2'd0;
  localparam logic [1:0] ST_DEGREE   = 2'd1;
  localparam logic [1:0] ST_UNREACH  = 2'd2;
  localparam logic [1:0] ST_BAD_EDGE = 2'd3;

  // One entry of the vertex store
  typedef struct packed {
    logic [EIDX_W-1:0] head;
    logic [DEG_W-1:0]  outd;
    logic [DEG_W-1:0]  ind;
  } vtx_entry_t;

  // Control strobes for the vertex store
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } vtx_ctl_t;

endpackage

### sv/eph_if.sv
// ----------------------------------------------------------------------------
// Eulerian path channel interfaces
// Valid/ready channels for edge items and path results.
// ----------------------------------------------------------------------------
interface eph_in_if import eph_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] source_vertex;
  logic [VTX_W-1:0] dest_vertex;
  logic             last_edge;

  modport source (output valid, source_vertex, dest_vertex, last_edge, input ready);
  modport sink   (input valid, source_vertex, dest_vertex, last_edge, output ready);
endinterface

interface eph_out_if import eph_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] vertex;
  logic             last;
  logic [1:0]       status;

  modport source (output valid, vertex, last, status, input ready);
  modport sink   (input valid, vertex, last, status, output ready);
endinterface

### sv/eph_ram.sv
// ----------------------------------------------------------------------------
// Eulerian path generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module eph_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/eph_vtx_store.sv
// ----------------------------------------------------------------------------
// Eulerian path vertex store
// Per-vertex list head and degree counts, with a valid bit per entry so that
// the whole store empties at once.
// ----------------------------------------------------------------------------
module eph_vtx_store import eph_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  vtx_ctl_t   ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  vtx_entry_t wr_data,
  output vtx_entry_t rd_data
);

  vtx_entry_t        mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  vtx_entry_t        rd_raw_r;
  logic              rd_vld_r;

  // Storage array.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits: set on write, all cleared at once.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read with the valid bit captured alongside.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_raw_r <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // An entry never written reads as empty list and zero degrees.
  always_comb begin
    if (rd_vld_r) begin
      rd_data = rd_raw_r;
    end else begin
      rd_data.head = EMPTY_MARK;
      rd_data.outd = '0;
      rd_data.ind  = '0;
    end
  end

endmodule

### sv/eulerian_path_directed.sv
// ----------------------------------------------------------------------------
// Directed Eulerian path engine
// Loads directed edges, checks degrees and walks Hierholzer's algorithm.
// ----------------------------------------------------------------------------
// Usage: edges arrive on in_ch one per transfer; the transfer with last_edge
// set starts the answer. cfg_we/cfg_wdata set vertex_count, the end vertex;
// the user must write it only while the block is idle (not enforced by the
// block). Results leave on out_ch: one transfer per path vertex from
// vertex 1 to the end vertex, or a single error transfer (vertex 0, last 1,
// non-zero status).
// Sequence: each edge is a read-modify-write of the tail entry, then of the
// head entry in the vertex store. The degree check reads every one of the
// MAX_VERTICES vertices. The walk reads the vertex, edge and stack memories
// through registered read ports; each path vertex is read from the path
// memory after the receiver takes the previous one.
// Reset empties the vertex store at once through per-vertex valid bits; no
// clearing pass is needed. While the receiver stalls, the result is held
// and no edge is taken. After the last result the graph is discarded.
// ----------------------------------------------------------------------------
module eulerian_path_directed import eph_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [VTX_W-1:0] cfg_wdata,
  eph_in_if.sink           in_ch,
  eph_out_if.source        out_ch
);

  localparam int VA_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W = $clog2(MAX_EDGES + 1);
  localparam int SP_W  = $clog2(MAX_EDGES + 2);
  localparam int PA_W  = $clog2(MAX_EDGES + 1);
  localparam int SP_MAX = MAX_EDGES + 1;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_L_RS   = 16'h0002,
    S_L_WS   = 16'h0004,
    S_L_RD   = 16'h0008,
    S_L_WD   = 16'h0010,
    S_CHK_RD = 16'h0020,
    S_CHK_EV = 16'h0040,
    S_W_RD   = 16'h0080,
    S_W_EV   = 16'h0100,
    S_W_ED   = 16'h0200,
    S_W_POP  = 16'h0400,
    S_W_END  = 16'h0800,
    S_O_RD   = 16'h1000,
    S_O_LD   = 16'h2000,
    S_O_WT   = 16'h4000,
    S_UNUSED = 16'h8000
  } state_t;

  state_t             state_r, state_nxt;
  logic [VTX_W-1:0]   vcount_r;
  logic [VTX_W-1:0]   src_r, src_nxt;
  logic [VTX_W-1:0]   dst_r, dst_nxt;
  logic               lastin_r, lastin_nxt;
  logic               fault_r, fault_nxt;
  logic [CNT_W-1:0]   edge_total_r, edge_total_nxt;
  logic [CNT_W-1:0]   taken_r, taken_nxt;
  logic [VTX_W-1:0]   chk_v_r, chk_v_nxt;
  logic [VTX_W-1:0]   top_r, top_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic [SP_W-1:0]    plen_r, plen_nxt;
  logic [PA_W-1:0]    idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0]   out_vertex_r, out_vertex_nxt;
  logic               out_last_r, out_last_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  logic [VTX_W-1:0]   n_end;
  logic               in_fire, out_fire, bad_edge;
  logic               deg_ok;

  // Memory ports.
  vtx_ctl_t           vctl;
  logic [VA_W-1:0]    v_raddr, v_waddr;
  vtx_entry_t         v_wdata, v_rdata;
  logic               e_we, e_re;
  logic [EA_W-1:0]    e_waddr, e_raddr;
  logic [VTX_W+EIDX_W-1:0] e_wdata, e_rdata;
  logic               s_we, s_re;
  logic [PA_W-1:0]    s_waddr, s_raddr;
  logic [VTX_W-1:0]   s_wdata, s_rdata;
  logic               p_we, p_re;
  logic [PA_W-1:0]    p_waddr, p_raddr;
  logic [VTX_W-1:0]   p_rdata;

  eph_vtx_store #(.DEPTH(MAX_VERTICES)) u_vtx (
    .clk(clk), .rst_n(rst_n), .ctl(vctl), .rd_addr(v_raddr), .wr_addr(v_waddr),
    .wr_data(v_wdata), .rd_data(v_rdata)
  );

  eph_ram #(.DEPTH(MAX_EDGES), .WIDTH(VTX_W + EIDX_W)) u_edge (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );

  eph_ram #(.DEPTH(MAX_EDGES + 1), .WIDTH(VTX_W)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  eph_ram #(.DEPTH(MAX_EDGES + 1), .WIDTH(VTX_W)) u_path (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(top_r),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  // Saturated end vertex.
  always_comb begin
    if (vcount_r < 7'd2) begin
      n_end = 7'd2;
    end else if (vcount_r > VTX_W'(MAX_VERTICES)) begin
      n_end = VTX_W'(MAX_VERTICES);
    end else begin
      n_end = vcount_r;
    end
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_fire      = out_valid_r && out_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.vertex = out_vertex_r;
  assign out_ch.last   = out_last_r;
  assign out_ch.status = out_status_r;

  assign bad_edge = (in_ch.source_vertex == '0) || (in_ch.source_vertex > n_end) ||
                    (in_ch.dest_vertex == '0) || (in_ch.dest_vertex > n_end) ||
                    (edge_total_r >= CNT_W'(MAX_EDGES));

  // Degree condition for the vertex under check.
  always_comb begin
    if (chk_v_r == START_VERTEX) begin
      deg_ok = ({1'b0, v_rdata.outd} == ({1'b0, v_rdata.ind} + 7'd1));
    end else if (chk_v_r == n_end) begin
      deg_ok = ({1'b0, v_rdata.ind} == ({1'b0, v_rdata.outd} + 7'd1));
    end else begin
      deg_ok = (v_rdata.outd == v_rdata.ind);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 7'd2;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  // Sequencer and memory accesses.
  always_comb begin
    state_nxt      = state_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    lastin_nxt     = lastin_r;
    fault_nxt      = fault_r;
    edge_total_nxt = edge_total_r;
    taken_nxt      = taken_r;
    chk_v_nxt      = chk_v_r;
    top_nxt        = top_r;
    sp_nxt         = sp_r;
    plen_nxt       = plen_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    out_vertex_nxt = out_vertex_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    vctl    = '0;
    v_raddr = '0;
    v_waddr = '0;
    v_wdata = v_rdata;
    e_we    = 1'b0;
    e_waddr = edge_total_r[EA_W-1:0];
    e_wdata = {dst_r, v_rdata.head};
    e_re    = 1'b0;
    e_raddr = v_rdata.head[EA_W-1:0];
    s_we    = 1'b0;
    s_waddr = PA_W'(sp_r - 1'b1);
    s_wdata = top_r;
    s_re    = 1'b0;
    s_raddr = PA_W'(sp_r - 2'd2);
    p_we    = 1'b0;
    p_waddr = PA_W'(plen_r);
    p_re    = 1'b0;
    p_raddr = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          src_nxt    = in_ch.source_vertex;
          dst_nxt    = in_ch.dest_vertex;
          lastin_nxt = in_ch.last_edge;
          if (bad_edge) begin
            fault_nxt = 1'b1;
            if (in_ch.last_edge) begin
              out_valid_nxt  = 1'b1;
              out_vertex_nxt = '0;
              out_last_nxt   = 1'b1;
              out_status_nxt = ST_BAD_EDGE;
              state_nxt      = S_O_WT;
            end
          end else begin
            state_nxt = S_L_RS;
          end
        end
      end
      S_L_RS: begin
        vctl.rd   = 1'b1;
        v_raddr   = VA_W'(src_r - 1'b1);
        state_nxt = S_L_WS;
      end
      S_L_WS: begin
        // Tail entry: new edge becomes the list head.
        vctl.wr        = 1'b1;
        v_waddr        = VA_W'(src_r - 1'b1);
        v_wdata.head   = EIDX_W'(edge_total_r);
        v_wdata.outd   = v_rdata.outd + 1'b1;
        e_we           = 1'b1;
        edge_total_nxt = edge_total_r + 1'b1;
        state_nxt      = S_L_RD;
      end
      S_L_RD: begin
        vctl.rd   = 1'b1;
        v_raddr   = VA_W'(dst_r - 1'b1);
        state_nxt = S_L_WD;
      end
      S_L_WD: begin
        vctl.wr     = 1'b1;
        v_waddr     = VA_W'(dst_r - 1'b1);
        v_wdata.ind = v_rdata.ind + 1'b1;
        if (!lastin_r) begin
          state_nxt = S_IDLE;
        end else if (fault_r) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_BAD_EDGE;
          state_nxt      = S_O_WT;
        end else begin
          chk_v_nxt = START_VERTEX;
          state_nxt = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        vctl.rd   = 1'b1;
        v_raddr   = VA_W'(chk_v_r - 1'b1);
        state_nxt = S_CHK_EV;
      end
      S_CHK_EV: begin
        if (!deg_ok) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_DEGREE;
          state_nxt      = S_O_WT;
        end else if (chk_v_r == VTX_W'(MAX_VERTICES)) begin
          top_nxt   = START_VERTEX;
          sp_nxt    = SP_W'(1);
          plen_nxt  = '0;
          taken_nxt = '0;
          state_nxt = S_W_RD;
        end else begin
          chk_v_nxt = chk_v_r + 1'b1;
          state_nxt = S_CHK_RD;
        end
      end
      S_W_RD: begin
        vctl.rd   = 1'b1;
        v_raddr   = VA_W'(top_r - 1'b1);
        state_nxt = S_W_EV;
      end
      S_W_EV: begin
        if (v_rdata.head < EIDX_W'(MAX_EDGES)) begin
          // Follow the newest unused edge.
          e_re      = 1'b1;
          state_nxt = S_W_ED;
        end else begin
          // Dead end: record the vertex and backtrack.
          p_we     = 1'b1;
          plen_nxt = plen_r + 1'b1;
          if (sp_r == SP_W'(1)) begin
            sp_nxt    = '0;
            state_nxt = S_W_END;
          end else begin
            s_re      = 1'b1;
            sp_nxt    = sp_r - 1'b1;
            state_nxt = S_W_POP;
          end
        end
      end
      S_W_ED: begin
        vctl.wr      = 1'b1;
        v_waddr      = VA_W'(top_r - 1'b1);
        v_wdata.head = e_rdata[EIDX_W-1:0];
        s_we         = 1'b1;
        top_nxt      = e_rdata[VTX_W+EIDX_W-1:EIDX_W];
        sp_nxt       = sp_r + 1'b1;
        taken_nxt    = taken_r + 1'b1;
        state_nxt    = S_W_RD;
      end
      S_W_POP: begin
        top_nxt   = s_rdata;
        state_nxt = S_W_RD;
      end
      S_W_END: begin
        if (taken_r != edge_total_r) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_UNREACH;
          state_nxt      = S_O_WT;
        end else begin
          idx_nxt   = PA_W'(plen_r - 1'b1);
          state_nxt = S_O_RD;
        end
      end
      S_O_RD: begin
        p_re      = 1'b1;
        state_nxt = S_O_LD;
      end
      S_O_LD: begin
        out_valid_nxt  = 1'b1;
        out_vertex_nxt = p_rdata;
        out_last_nxt   = (idx_r == '0);
        out_status_nxt = ST_PATH;
        state_nxt      = S_O_WT;
      end
      S_O_WT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // Discard the graph after the final transfer.
            vctl.clr       = 1'b1;
            edge_total_nxt = '0;
            fault_nxt      = 1'b0;
            taken_nxt      = '0;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_O_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fault_r      <= 1'b0;
      edge_total_r <= '0;
      taken_r      <= '0;
      sp_r         <= '0;
      plen_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fault_r      <= fault_nxt;
      edge_total_r <= edge_total_nxt;
      taken_r      <= taken_nxt;
      sp_r         <= sp_nxt;
      plen_r       <= plen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    lastin_r     <= lastin_nxt;
    chk_v_r      <= chk_v_nxt;
    top_r        <= top_nxt;
    idx_r        <= idx_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  // No edge is taken while a result is pending.
  a_no_in_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("edge taken while result pending");

  // The walk stack never grows past MAX_EDGES plus one.
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(SP_MAX)) else $error("walk stack overflow");

  // No more edges are traversed than were stored.
  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= edge_total_r) else $error("edges traversed exceed edges stored");

  // An error result is always a single final item with vertex zero.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_PATH) |-> (out_ch.last && out_ch.vertex == '0))
    else $error("malformed error result");
`endif

endmodule
